// ----- hdl/dpfc_pkg.sv -----
package dpfc_pkg;

	localparam int QueueDepth = 2;
	localparam int MaxBytes   = 4;

	// register indexes on the configuration port
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_CLUT0 = 3'd1;
	localparam logic [2:0] REG_CLUT1 = 3'd2;
	localparam logic [2:0] REG_CLUT2 = 3'd3;
	localparam logic [2:0] REG_CLUT3 = 3'd4;

	typedef enum logic [2:0] {
		MODE_PASS     = 3'd0,
		MODE_SWAP16   = 3'd1,
		MODE_RGB444   = 3'd2,
		MODE_RGB332   = 3'd3,
		MODE_GRAY8    = 3'd4,
		MODE_GRAY4    = 3'd5,
		MODE_PALETTE4 = 3'd6
	} mode_t;

	// converted bytes of one input item, bytes[0] sent first
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0]               count;
		logic                     last;
	} bundle_t;

	function automatic logic [15:0] gray4_pixel(input logic [3:0] nib);
		logic [5:0] g6;
		logic [4:0] g5;
		g6 = {nib, nib[3:2]};
		g5 = {nib, nib[3]};
		return {g5, g6, g5};
	endfunction

endpackage

// ----- hdl/dpfc_if.sv -----
interface dpfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface dpfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source(output valid, out_byte, out_last, input ready);
	modport sink(input valid, out_byte, out_last, output ready);
endinterface

// ----- hdl/display_pixel_format_converter.sv -----
// channel  dir  payload                 accepted when
// src      in   data_byte, last_byte    src.valid & src.ready
// dst      out  out_byte, out_last      dst.valid & dst.ready
// cfg      in   cfg_index, cfg_data     cfg_we
//
// an item produces up to 4 output bytes, sent one per cycle while dst is ready and
// paced by the byte-wide output register; the front takes a new item every cycle the queue
// has room, so items that give no byte or one byte flow back to back
// reset clears mode, palette, pixel state, queue and output valid
// either side may stall; the queue between front and back absorbs the skew
module display_pixel_format_converter #(
	parameter int QUEUE_DEPTH = dpfc_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	dpfc_in_if.sink     src,
	dpfc_out_if.source  dst
);
	import dpfc_pkg::*;

	bundle_t push_data;
	bundle_t head;
	logic    push;
	logic    pop;
	logic    full;
	logic    empty;

	dpfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src       (src),
		.q_full    (full),
		.push      (push),
		.push_data (push_data)
	);

	dpfc_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	dpfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.dst    (dst)
	);

endmodule

// ----- hdl/dpfc_front.sv -----
module dpfc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	dpfc_in_if.sink           src,
	input  logic              q_full,
	output logic              push,
	output dpfc_pkg::bundle_t push_data
);
	import dpfc_pkg::*;

	logic [2:0]       mode_q;
	logic [3:0][63:0] clut_q;
	logic [7:0]       held_byte_q;
	logic             byte_phase_q;
	logic             pixel_phase_q;
	logic [3:0]       saved_blue_q;

	logic [7:0]  held_n;
	logic        bp_n;
	logic        pp_n;
	logic [3:0]  sb_n;
	logic        accept;
	logic [7:0]  d;
	logic [15:0] px;
	logic [15:0] px_lo;
	logic [15:0] px_a;
	logic [15:0] px_b;
	logic [2:0]  r3;
	logic [2:0]  g3;
	logic [1:0]  b2;
	bundle_t     bnd;

	function automatic logic [15:0] pal(input logic [3:0][63:0] tbl, input logic [3:0] idx);
		return tbl[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
	endfunction

	assign src.ready = !q_full;
	assign accept    = src.valid && !q_full;
	assign d         = src.data_byte;

	always_comb begin
		held_n = held_byte_q;
		bp_n   = byte_phase_q;
		pp_n   = pixel_phase_q;
		sb_n   = saved_blue_q;
		bnd    = '0;
		px     = {d, held_byte_q};
		px_lo  = '0;
		px_a   = '0;
		px_b   = '0;
		r3     = d[7:5];
		g3     = d[4:2];
		b2     = d[1:0];
		case (mode_t'(mode_q))
			MODE_SWAP16: begin
				if (!byte_phase_q) begin
					held_n = d;
					bp_n   = 1'b1;
					if (src.last_byte) begin
						bnd.bytes[0] = d;
						bnd.count    = 3'd1;
					end
				end else begin
					bnd.bytes[0] = d;
					bnd.bytes[1] = held_byte_q;
					bnd.count    = 3'd2;
					bp_n         = 1'b0;
				end
			end
			MODE_RGB444: begin
				if (!byte_phase_q) begin
					held_n = d;
					bp_n   = 1'b1;
					if (src.last_byte && pixel_phase_q) begin
						bnd.bytes[0] = {saved_blue_q, 4'b0000};
						bnd.count    = 3'd1;
					end
				end else begin
					bp_n = 1'b0;
					if (!pixel_phase_q) begin
						bnd.bytes[0] = {px[15:12], px[10:7]};
						sb_n         = px[4:1];
						pp_n         = 1'b1;
						if (src.last_byte) begin
							bnd.bytes[1] = {px[4:1], 4'b0000};
							bnd.count    = 3'd2;
						end else begin
							bnd.count = 3'd1;
						end
					end else begin
						bnd.bytes[0] = {saved_blue_q, px[15:12]};
						bnd.bytes[1] = {px[10:7], px[4:1]};
						bnd.count    = 3'd2;
						pp_n         = 1'b0;
					end
				end
			end
			MODE_RGB332: begin
				// widen each channel by bit replication
				px_lo        = {r3, r3[2:1], g3, g3, b2, b2, b2[1]};
				bnd.bytes[0] = px_lo[15:8];
				bnd.bytes[1] = px_lo[7:0];
				bnd.count    = 3'd2;
			end
			MODE_GRAY8: begin
				px_lo        = {d[7:3], d[7:2], d[7:3]};
				bnd.bytes[0] = px_lo[15:8];
				bnd.bytes[1] = px_lo[7:0];
				bnd.count    = 3'd2;
			end
			MODE_GRAY4: begin
				px_a         = gray4_pixel(d[7:4]);
				px_b         = gray4_pixel(d[3:0]);
				bnd.bytes[0] = px_a[15:8];
				bnd.bytes[1] = px_a[7:0];
				bnd.bytes[2] = px_b[15:8];
				bnd.bytes[3] = px_b[7:0];
				bnd.count    = 3'd4;
			end
			MODE_PALETTE4: begin
				px_a         = pal(clut_q, d[7:4]);
				px_b         = pal(clut_q, d[3:0]);
				bnd.bytes[0] = px_a[15:8];
				bnd.bytes[1] = px_a[7:0];
				bnd.bytes[2] = px_b[15:8];
				bnd.bytes[3] = px_b[7:0];
				bnd.count    = 3'd4;
			end
			default: begin
				bnd.bytes[0] = d;
				bnd.count    = 3'd1;
			end
		endcase
		bnd.last = src.last_byte;
		if (src.last_byte) begin
			bp_n = 1'b0;
			pp_n = 1'b0;
		end
	end

	assign push      = accept && (bnd.count != 3'd0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_PASS;
			clut_q        <= '0;
			held_byte_q   <= '0;
			byte_phase_q  <= 1'b0;
			pixel_phase_q <= 1'b0;
			saved_blue_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: begin
					mode_q        <= cfg_data[2:0];
					byte_phase_q  <= 1'b0;
					pixel_phase_q <= 1'b0;
				end
				REG_CLUT0: clut_q[0] <= cfg_data;
				REG_CLUT1: clut_q[1] <= cfg_data;
				REG_CLUT2: clut_q[2] <= cfg_data;
				REG_CLUT3: clut_q[3] <= cfg_data;
				default: ;
			endcase
		end else if (accept) begin
			held_byte_q   <= held_n;
			byte_phase_q  <= bp_n;
			pixel_phase_q <= pp_n;
			saved_blue_q  <= sb_n;
		end
	end

endmodule

// ----- hdl/dpfc_queue.sv -----
module dpfc_queue #(
	parameter int Depth = dpfc_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dpfc_pkg::bundle_t push_data,
	input  logic              pop,
	output dpfc_pkg::bundle_t head,
	output logic              full,
	output logic              empty
);
	import dpfc_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	bundle_t         mem_q [Depth];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full  = (fill_q == CW'(Depth));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/dpfc_back.sv -----
module dpfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dpfc_pkg::bundle_t head,
	input  logic              empty,
	output logic              pop,
	dpfc_out_if.source        dst
);
	import dpfc_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       final_byte;

	assign load       = !empty && (!out_valid_q || dst.ready);
	assign final_byte = ({1'b0, idx_q} == (head.count - 3'd1));
	assign pop        = load && final_byte;

	assign dst.valid    = out_valid_q;
	assign dst.out_byte = out_byte_q;
	assign dst.out_last = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			out_last_q <= head.last && final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
